/* rtl/smf_pkg.sv */
// ----------------------------------------------------------------------------
// smf_pkg
// Shared types and constants of the serial message framer: byte codes,
// register indexes, configuration and ingest status structs.
// ----------------------------------------------------------------------------
package smf_pkg;

    localparam int LEN_W  = 7;
    localparam int POS_W  = 6;
    localparam int BYTE_W = 8;
    localparam int IDX_W  = 3;

    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [BYTE_W-1:0] byte_t;

    // special byte codes
    localparam byte_t BYTE_LF    = 8'h0A;
    localparam byte_t BYTE_CR    = 8'h0D;
    localparam byte_t BYTE_SPACE = 8'h20;
    localparam byte_t BYTE_TAB   = 8'h09;
    localparam byte_t BYTE_FF    = 8'hFF;
    localparam byte_t BYTE_QHEAD = 8'h71;

    // minimum fill before a triple 0xFF terminator counts
    localparam len_t MIN_FILL_QHEAD = 7'd7;
    localparam len_t MIN_FILL_FF    = 7'd2;

    // register indexes
    localparam logic [IDX_W-1:0] CFG_MAX_LENGTH   = 3'd0;
    localparam logic [IDX_W-1:0] CFG_IGNORE_LF    = 3'd1;
    localparam logic [IDX_W-1:0] CFG_TRIPLE_FF    = 3'd2;
    localparam logic [IDX_W-1:0] CFG_KEEP_DELIM   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_PASS_EMPTY   = 3'd4;
    localparam logic [IDX_W-1:0] CFG_SKIP_SPACE   = 3'd5;

    typedef struct packed {
        len_t max_length;
        logic ignore_lf;
        logic triple_ff_mode;
        logic keep_delimiter;
        logic pass_empty;
        logic skip_leading_space;
    } cfg_t;

    // message completion status from the ingest stage
    typedef struct packed {
        logic done;
        len_t length;
    } ingest_t;

endpackage

/* rtl/smf_ram.sv */
// ----------------------------------------------------------------------------
// smf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds while not enabled
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/smf_ingest.sv */
// ----------------------------------------------------------------------------
// smf_ingest
// Per-byte framing decision: drop, skip, store or terminate. Keeps the fill
// count and shadow flags for the terminator test, drives the store writes.
// ----------------------------------------------------------------------------
module smf_ingest #(
    parameter int MAX_MESSAGE = 64,
    parameter int ADDR_W      = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  smf_pkg::cfg_t        cfg,
    input  logic                 accept,
    input  smf_pkg::byte_t       in_byte,
    output logic                 wr_en,
    output logic [ADDR_W-1:0]    wr_addr,
    output smf_pkg::byte_t       wr_data,
    output smf_pkg::ingest_t     status
);

    localparam smf_pkg::len_t MAX_LEN = smf_pkg::len_t'(MAX_MESSAGE);

    smf_pkg::len_t fill_reg, fill_next;
    logic [1:0]    trail_ff_reg, trail_ff_next;
    logic          first_q_reg, first_q_next;

    logic          lf_drop, cr_term, ff_term, delim, is_space, skip, active;
    logic          store, strip, is_ff;
    smf_pkg::len_t limit, min_fill, fill_inc, fill_after;

    // framing decision for the offered byte
    always_comb begin
        is_ff    = (in_byte == smf_pkg::BYTE_FF);
        limit    = (cfg.max_length == '0 || cfg.max_length > MAX_LEN) ? MAX_LEN
                                                                     : cfg.max_length;
        min_fill = first_q_reg ? smf_pkg::MIN_FILL_QHEAD : smf_pkg::MIN_FILL_FF;
        lf_drop  = (in_byte == smf_pkg::BYTE_LF) && cfg.ignore_lf;
        cr_term  = (in_byte == smf_pkg::BYTE_CR) && !cfg.triple_ff_mode;
        ff_term  = cfg.triple_ff_mode && is_ff && (fill_reg >= min_fill)
                   && (trail_ff_reg == 2'd2);
        delim    = cr_term || ff_term;
        is_space = (in_byte == smf_pkg::BYTE_SPACE) || (in_byte == smf_pkg::BYTE_TAB);
        skip     = !delim && (fill_reg == '0) && cfg.skip_leading_space && is_space;
        active   = accept && !lf_drop && !skip;
        store    = active && (!delim || cfg.keep_delimiter) && (fill_reg < MAX_LEN);
        strip    = active && ff_term && !cfg.keep_delimiter;
        fill_inc = fill_reg + (store ? 7'd1 : 7'd0);
        fill_after = strip ? (fill_inc - 7'd2) : fill_inc;

        status.length = fill_after;
        if (!active) begin
            status.done = 1'b0;
        end else if (delim) begin
            status.done = (fill_after != '0) || cfg.pass_empty;
        end else begin
            status.done = (fill_after >= limit);
        end
    end

    // fill count and shadow flags
    always_comb begin
        fill_next     = status.done ? '0 : fill_after;
        first_q_next  = first_q_reg;
        trail_ff_next = trail_ff_reg;
        if (store && fill_reg == '0) begin
            first_q_next = (in_byte == smf_pkg::BYTE_QHEAD);
        end
        if (fill_next == '0) begin
            trail_ff_next = 2'd0;
        end else if (store) begin
            if (!is_ff) begin
                trail_ff_next = 2'd0;
            end else if (trail_ff_reg != 2'd2) begin
                trail_ff_next = trail_ff_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            trail_ff_reg <= 2'd0;
            first_q_reg  <= 1'b0;
        end else begin
            fill_reg     <= fill_next;
            trail_ff_reg <= trail_ff_next;
            first_q_reg  <= first_q_next;
        end
    end

    // store write port
    assign wr_en   = store;
    assign wr_addr = fill_reg[ADDR_W-1:0];
    assign wr_data = in_byte;

endmodule

/* rtl/serial_message_framer_unit.sv */
// ----------------------------------------------------------------------------
// serial_message_framer_unit
// Collects received bytes into a message store and sends each completed
// message out as a run of words with position, length, empty flag and last.
// ----------------------------------------------------------------------------
// Output: the first word of a message is offered after the store read state
// entered at the edge accepting the word completing it; an empty message
// word is offered right after that edge. Input: a byte that does not end a
// message is taken without holding off further bytes; a run of words holds
// input off until its last word is accepted, output stalls included. Reset:
// control state, configuration and ingest registers take reset values, not the
// run registers; the store is never cleared (only written entries are read).
module serial_message_framer_unit #(
    parameter int MAX_MESSAGE = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wen,
    input  logic [2:0]  cfg_index,
    input  logic [6:0]  cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] msg_byte, [13:8] byte_position,
                                   // [20:14] msg_length, [23:21] zero
    output logic        m_tuser,   // [0] is_empty
    output logic        m_tlast
);

    localparam int ADDR_W = $clog2(MAX_MESSAGE);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_SEND = 2'd2;

    logic [1:0]              state_reg, state_next;
    smf_pkg::len_t           len_reg, len_next;
    logic [smf_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                    empty_reg, empty_next;
    smf_pkg::cfg_t           cfg_reg;

    logic                    s_accept, m_accept, is_last;
    logic                    wr_en, rd_en;
    logic [ADDR_W-1:0]       wr_addr;
    smf_pkg::byte_t          wr_data, rd_data;
    smf_pkg::ingest_t        status;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_length         <= 7'd64;
            cfg_reg.ignore_lf          <= 1'b0;
            cfg_reg.triple_ff_mode     <= 1'b0;
            cfg_reg.keep_delimiter     <= 1'b0;
            cfg_reg.pass_empty         <= 1'b0;
            cfg_reg.skip_leading_space <= 1'b0;
        end else if (cfg_wen) begin
            case (cfg_index)
                smf_pkg::CFG_MAX_LENGTH: cfg_reg.max_length         <= cfg_wdata;
                smf_pkg::CFG_IGNORE_LF:  cfg_reg.ignore_lf          <= cfg_wdata[0];
                smf_pkg::CFG_TRIPLE_FF:  cfg_reg.triple_ff_mode     <= cfg_wdata[0];
                smf_pkg::CFG_KEEP_DELIM: cfg_reg.keep_delimiter     <= cfg_wdata[0];
                smf_pkg::CFG_PASS_EMPTY: cfg_reg.pass_empty         <= cfg_wdata[0];
                smf_pkg::CFG_SKIP_SPACE: cfg_reg.skip_leading_space <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == ST_SEND);
    assign m_accept = m_tvalid && m_tready;
    assign is_last  = empty_reg || (({1'b0, pos_reg} + 7'd1) == len_reg);

    smf_ingest #(
        .MAX_MESSAGE (MAX_MESSAGE),
        .ADDR_W      (ADDR_W)
    ) u_ingest (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .accept  (s_accept),
        .in_byte (s_tdata),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .status  (status)
    );

    smf_ram #(
        .WIDTH (smf_pkg::BYTE_W),
        .DEPTH (MAX_MESSAGE)
    ) u_store (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (pos_next[ADDR_W-1:0]),
        .rdata (rd_data)
    );

    // run sequencer: start read, then one word per handshake
    always_comb begin
        state_next = state_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        empty_next = empty_reg;
        rd_en      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (status.done) begin
                    len_next   = status.length;
                    pos_next   = '0;
                    empty_next = (status.length == '0);
                    state_next = (status.length == '0) ? ST_SEND : ST_READ;
                end
            end
            ST_READ: begin
                rd_en      = 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (m_accept) begin
                    if (is_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        pos_next = pos_reg + 6'd1;
                        rd_en    = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg   <= len_next;
        pos_reg   <= pos_next;
        empty_reg <= empty_next;
    end

    // result word
    assign m_tdata = {3'b000, len_reg, (empty_reg ? 6'd0 : pos_reg),
                      (empty_reg ? 8'd0 : rd_data)};
    assign m_tuser = empty_reg;
    assign m_tlast = is_last;

    // input is never taken while a run is out
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready during a message run");

    // an empty message is a single word
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("empty message word not marked last");

    // a completed message holds off the next input
    a_done_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && status.done) |=> !s_tready)
        else $error("input taken right after a completed message");

    // a data word lies inside the message
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> ({1'b0, pos_reg} < len_reg))
        else $error("byte position beyond message length");

endmodule

/* tb/smf_frame_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// smf_frame_checker
// Passive checker for the serial message framer. Tracks register writes,
// rebuilds each message from the accepted input words, queues the words the
// block should send, and compares every accepted output word field by field.
// ----------------------------------------------------------------------------
module smf_frame_checker #(
    parameter int MAX_MESSAGE = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [2:0]  cfg_index,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    output int          mismatch_count,
    output int          pending_words
);

    // one output word as the block should send it
    typedef struct packed {
        smf_pkg::byte_t            msg_byte;
        logic [smf_pkg::POS_W-1:0] position;
        smf_pkg::len_t             length;
        logic                      is_empty;
        logic                      last;
    } frame_word_t;

    smf_pkg::cfg_t  shadow_cfg;
    smf_pkg::byte_t msg_store [MAX_MESSAGE];
    int             fill;
    frame_word_t    expected_words [$];

    task automatic store_byte(input smf_pkg::byte_t b);
        if (fill < MAX_MESSAGE) begin
            msg_store[fill] = b;
            fill++;
        end
    endtask

    // queue the run of words for the message held in the store
    task automatic queue_message();
        frame_word_t w;
        if (fill == 0) begin
            w = '{msg_byte: '0, position: '0, length: '0, is_empty: 1'b1, last: 1'b1};
            expected_words.push_back(w);
        end else begin
            for (int k = 0; k < fill; k++) begin
                w.msg_byte = msg_store[k];
                w.position = k[smf_pkg::POS_W-1:0];
                w.length   = smf_pkg::len_t'(fill);
                w.is_empty = 1'b0;
                w.last     = (k + 1 == fill);
                expected_words.push_back(w);
            end
        end
        fill = 0;
    endtask

    // framing decision for one received byte
    task automatic absorb_rx_byte(input smf_pkg::byte_t b);
        int   lim;
        int   need;
        logic done;
        done = 1'b0;
        lim  = (shadow_cfg.max_length == 0 || shadow_cfg.max_length > MAX_MESSAGE) ?
               MAX_MESSAGE : int'(shadow_cfg.max_length);
        if (b == smf_pkg::BYTE_LF && shadow_cfg.ignore_lf)
            return;
        need = (msg_store[0] == smf_pkg::BYTE_QHEAD) ? int'(smf_pkg::MIN_FILL_QHEAD)
                                                     : int'(smf_pkg::MIN_FILL_FF);
        if (b == smf_pkg::BYTE_CR && !shadow_cfg.triple_ff_mode) begin
            if (shadow_cfg.keep_delimiter)
                store_byte(b);
            done = (fill != 0) || shadow_cfg.pass_empty;
        end else if (shadow_cfg.triple_ff_mode && b == smf_pkg::BYTE_FF && fill >= 2 &&
                     fill >= need && msg_store[fill-1] == smf_pkg::BYTE_FF &&
                     msg_store[fill-2] == smf_pkg::BYTE_FF) begin
            // third 0xFF in a row closes the message
            if (shadow_cfg.keep_delimiter)
                store_byte(b);
            else
                fill -= 2;
            done = (fill != 0) || shadow_cfg.pass_empty;
        end else begin
            if (fill == 0 && shadow_cfg.skip_leading_space &&
                (b == smf_pkg::BYTE_SPACE || b == smf_pkg::BYTE_TAB))
                return;
            store_byte(b);
            done = (fill >= lim);
        end
        if (done)
            queue_message();
    endtask

    task automatic check_word(input logic [23:0] data, input logic empty_flag,
                              input logic last_flag);
        frame_word_t want;
        if (expected_words.size() == 0) begin
            $error("unexpected word: tdata %h tuser %b tlast %b", data, empty_flag, last_flag);
            mismatch_count++;
            return;
        end
        want = expected_words.pop_front();
        if (data[7:0] !== want.msg_byte) begin
            $error("msg_byte: expected %02h, got %02h", want.msg_byte, data[7:0]);
            mismatch_count++;
        end
        if (data[13:8] !== want.position) begin
            $error("byte_position: expected %0d, got %0d", want.position, data[13:8]);
            mismatch_count++;
        end
        if (data[20:14] !== want.length) begin
            $error("msg_length: expected %0d, got %0d", want.length, data[20:14]);
            mismatch_count++;
        end
        if (empty_flag !== want.is_empty) begin
            $error("is_empty: expected %b, got %b", want.is_empty, empty_flag);
            mismatch_count++;
        end
        if (last_flag !== want.last) begin
            $error("last: expected %b, got %b", want.last, last_flag);
            mismatch_count++;
        end
    endtask

    // sample both channels and the register port at each rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            mismatch_count = 0;
            fill           = 0;
            shadow_cfg = '{max_length: 7'd64, ignore_lf: 1'b0, triple_ff_mode: 1'b0,
                           keep_delimiter: 1'b0, pass_empty: 1'b0,
                           skip_leading_space: 1'b0};
            expected_words.delete();
        end else begin
            if (m_tvalid && m_tready)
                check_word(m_tdata, m_tuser, m_tlast);
            // the byte taken at this edge still sees the old settings
            if (s_tvalid && s_tready)
                absorb_rx_byte(s_tdata);
            if (cfg_wen) begin
                case (cfg_index)
                    smf_pkg::CFG_MAX_LENGTH: shadow_cfg.max_length         = cfg_wdata;
                    smf_pkg::CFG_IGNORE_LF:  shadow_cfg.ignore_lf          = cfg_wdata[0];
                    smf_pkg::CFG_TRIPLE_FF:  shadow_cfg.triple_ff_mode     = cfg_wdata[0];
                    smf_pkg::CFG_KEEP_DELIM: shadow_cfg.keep_delimiter     = cfg_wdata[0];
                    smf_pkg::CFG_PASS_EMPTY: shadow_cfg.pass_empty         = cfg_wdata[0];
                    smf_pkg::CFG_SKIP_SPACE: shadow_cfg.skip_leading_space = cfg_wdata[0];
                    default: ;
                endcase
            end
        end
        pending_words = expected_words.size();
    end

endmodule

/* tb/tb_serial_message_framer_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_serial_message_framer_unit
// Drives received bytes and register writes into the framer: a short
// directed pass over terminators, options and limits, then random phases of
// mostly well-formed messages under changing settings, with random gaps on
// both channels. The checker beside the block scores the output words.
// ----------------------------------------------------------------------------
module tb_serial_message_framer_unit;

    localparam logic [smf_pkg::IDX_W-1:0] CFG_NO_SUCH_REG = 3'd7;
    localparam int                        PHASE_ITEMS     = 12;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wen   = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [6:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    logic        s_took    = 1'b0;
    logic        calm      = 1'b0;
    logic        ff_mode   = 1'b0;
    int          mismatch_count;
    int          pending_words;
    int          bytes_sent = 0;

    serial_message_framer_unit #(.MAX_MESSAGE(64)) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    smf_frame_checker #(.MAX_MESSAGE(64)) checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wen        (cfg_wen),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .pending_words  (pending_words)
    );

    always #5 aclk = ~aclk;

    // input word handshake seen at the last rising edge
    always @(posedge aclk) begin
        s_took <= s_tvalid && s_tready;
    end

    // output side back-pressure
    always @(negedge aclk) begin
        m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 29);
    end

    // run limit
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_byte(input smf_pkg::byte_t b);
        if (!calm) begin
            while ($urandom_range(0, 99) < 29) begin
                s_tvalid = 1'b0;
                @(negedge aclk);
            end
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        do @(negedge aclk); while (!s_took);
        bytes_sent++;
    endtask

    // stop sending and let the block finish every message in flight
    task automatic settle();
        s_tvalid = 1'b0;
        while (pending_words != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [smf_pkg::IDX_W-1:0] idx, input int value);
        cfg_wen   = 1'b1;
        cfg_index = idx;
        cfg_wdata = value[6:0];
        @(negedge aclk);
        cfg_wen   = 1'b0;
    endtask

    // payload byte with the special codes weighted up
    function automatic smf_pkg::byte_t pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)  return smf_pkg::BYTE_SPACE;
        if (r < 12) return smf_pkg::BYTE_TAB;
        if (r < 17) return smf_pkg::BYTE_LF;
        if (r < 20) return smf_pkg::BYTE_CR;
        if (r < 26) return smf_pkg::BYTE_FF;
        if (r < 29) return smf_pkg::BYTE_QHEAD;
        return smf_pkg::byte_t'($urandom_range(0, 255));
    endfunction

    // payload then the terminator of the chosen mode
    task automatic send_message(input logic use_ff, input int len);
        if (use_ff && len > 0 && $urandom_range(0, 3) == 0) begin
            send_byte(smf_pkg::BYTE_QHEAD);
            len--;
        end
        for (int i = 0; i < len; i++)
            send_byte(pick_byte());
        if (use_ff) begin
            repeat (3) send_byte(smf_pkg::BYTE_FF);
        end else begin
            send_byte(smf_pkg::BYTE_CR);
        end
    endtask

    task automatic set_all(input int max_len, input int lf, input int ff, input int keep,
                           input int empty_ok, input int skip);
        write_reg(smf_pkg::CFG_MAX_LENGTH, max_len);
        write_reg(smf_pkg::CFG_IGNORE_LF, lf);
        write_reg(smf_pkg::CFG_TRIPLE_FF, ff);
        write_reg(smf_pkg::CFG_KEEP_DELIM, keep);
        write_reg(smf_pkg::CFG_PASS_EMPTY, empty_ok);
        write_reg(smf_pkg::CFG_SKIP_SPACE, skip);
        ff_mode = ff[0];
    endtask

    initial begin
        int max_len;
        int ff;
        int keep;
        int goal;
        int r;

        repeat (9) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // reset settings: lf and 0xff are plain bytes, bare cr gives nothing
        send_byte(8'h41);
        send_byte(smf_pkg::BYTE_FF);
        send_byte(smf_pkg::BYTE_LF);
        send_byte(smf_pkg::BYTE_CR);
        send_byte(smf_pkg::BYTE_CR);
        settle();

        // drop lf, skip leading blanks, keep the cr
        write_reg(smf_pkg::CFG_PASS_EMPTY, 1);
        write_reg(smf_pkg::CFG_KEEP_DELIM, 1);
        write_reg(smf_pkg::CFG_IGNORE_LF, 1);
        write_reg(smf_pkg::CFG_SKIP_SPACE, 1);
        send_byte(smf_pkg::BYTE_SPACE);
        send_byte(smf_pkg::BYTE_TAB);
        send_byte(smf_pkg::BYTE_LF);
        send_byte(8'h41);
        send_byte(smf_pkg::BYTE_CR);
        settle();

        // triple 0xff: 0x71 head needs seven bytes, cr is plain, empty reported
        write_reg(smf_pkg::CFG_TRIPLE_FF, 1);
        write_reg(smf_pkg::CFG_KEEP_DELIM, 0);
        send_byte(smf_pkg::BYTE_QHEAD);
        repeat (3) send_byte(smf_pkg::BYTE_FF);
        send_byte(smf_pkg::BYTE_CR);
        repeat (3) send_byte(smf_pkg::BYTE_FF);
        repeat (3) send_byte(smf_pkg::BYTE_FF);
        settle();

        // single byte limit, then kept triple terminator
        write_reg(smf_pkg::CFG_KEEP_DELIM, 1);
        write_reg(smf_pkg::CFG_MAX_LENGTH, 1);
        send_byte(8'h00);
        settle();
        write_reg(smf_pkg::CFG_MAX_LENGTH, 8);
        repeat (3) send_byte(smf_pkg::BYTE_FF);
        settle();

        // limit lowered under the fill, kept cr runs past it
        write_reg(smf_pkg::CFG_TRIPLE_FF, 0);
        write_reg(smf_pkg::CFG_MAX_LENGTH, 64);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'h03);
        settle();
        write_reg(smf_pkg::CFG_MAX_LENGTH, 2);
        write_reg(CFG_NO_SUCH_REG, 0);
        send_byte(smf_pkg::BYTE_CR);
        settle();

        // random phases
        for (int phase = 0; phase < 8; phase++) begin
            ff   = $urandom_range(0, 1);
            keep = $urandom_range(0, 1);
            case (phase)
                0: max_len = 64;
                1: max_len = 1;
                2: begin
                    max_len = 0;
                    ff      = 0;
                    keep    = 1;
                end
                3: max_len = 127;
                4: max_len = $urandom_range(2, 12);
                5: begin
                    max_len = $urandom_range(1, 64);
                    ff      = 1;
                end
                6: begin
                    max_len = 3;
                    ff      = 1;
                    keep    = 1;
                end
                default: max_len = $urandom_range(1, 64);
            endcase
            calm = (phase == 3 || phase == 4);
            set_all(max_len, $urandom_range(0, 1), ff, keep, $urandom_range(0, 1),
                    $urandom_range(0, 1));

            // full store closed by a kept cr
            if (phase == 2) begin
                for (int i = 0; i < 63; i++)
                    send_byte(smf_pkg::byte_t'($urandom_range(33, 126)));
                send_byte(smf_pkg::BYTE_CR);
            end

            goal = bytes_sent + PHASE_ITEMS;
            while (bytes_sent < goal) begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    send_message(ff_mode, $urandom_range(55, 70));
                else if (r < 78)
                    send_message(ff_mode, $urandom_range(0, 9));
                else if (r < 88)
                    send_message(!ff_mode, $urandom_range(0, 6));
                else
                    repeat ($urandom_range(1, 5))
                        send_byte(smf_pkg::byte_t'($urandom_range(0, 255)));
            end
            settle();
        end
        calm = 1'b0;

        settle();
        repeat (8) @(negedge aclk);
        if (mismatch_count == 0 && pending_words == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/smf_pkg.sv
rtl/smf_ram.sv
rtl/smf_ingest.sv
rtl/serial_message_framer_unit.sv
tb/smf_frame_checker.sv
tb/tb_serial_message_framer_unit.sv
